FILE: rtl/odlc_pkg.sv
// ----------------------------------------------------------------------------
// odlc_pkg
// Types and constants shared by the lamp controller modules.
// ----------------------------------------------------------------------------
package odlc_pkg;

	localparam logic [2:0] ACT_TICK     = 3'd0;
	localparam logic [2:0] ACT_MODE     = 3'd1;
	localparam logic [2:0] ACT_UP       = 3'd2;
	localparam logic [2:0] ACT_DOWN     = 3'd3;
	localparam logic [2:0] ACT_PRESENCE = 3'd4;
	localparam logic [2:0] ACT_SAMPLE   = 3'd5;

	localparam logic [2:0] REG_BAND_DARKEST = 3'd0;
	localparam logic [2:0] REG_BAND_DIM     = 3'd1;
	localparam logic [2:0] REG_BAND_MIDDLE  = 3'd2;
	localparam logic [2:0] REG_BAND_BRIGHT  = 3'd3;
	localparam logic [2:0] REG_BAND_TOP     = 3'd4;
	localparam logic [2:0] REG_VACANCY      = 3'd5;
	localparam logic [2:0] REG_TICKS        = 3'd6;

	localparam logic [2:0] LEVEL_MAX    = 3'd4;
	localparam logic [2:0] LEVEL_MEDIUM = 3'd2;
	localparam logic [6:0] PWM_STEPS    = 7'd100;

	typedef struct packed {
		logic [2:0]  action;
		logic [11:0] light_level;
	} req_item_t;

	typedef struct packed {
		logic       lamp_on;
		logic [2:0] level;
		logic       auto_mode;
		logic       occupied;
	} rsp_item_t;

	typedef struct packed {
		logic [11:0] band_darkest;
		logic [11:0] band_dim;
		logic [11:0] band_middle;
		logic [11:0] band_bright;
		logic [11:0] band_top;
		logic [15:0] vacancy_seconds;
		logic [13:0] ticks_per_second;
	} cfg_t;

	typedef struct packed {
		logic        mode_is_auto;
		logic [2:0]  level;
		logic        present;
		logic        timing_active;
		logic [13:0] tick_prescale;
		logic [15:0] elapsed_seconds;
		logic [6:0]  pwm_phase;
		logic        drive_out;
	} lamp_state_t;

	function automatic logic [6:0] duty_of_level(input logic [2:0] lvl);
		logic [6:0] d;
		begin
			unique case (lvl)
				3'd0: d = 7'd0;
				3'd1: d = 7'd25;
				3'd2: d = 7'd50;
				3'd3: d = 7'd75;
				3'd4: d = 7'd100;
				default: d = 7'd0;
			endcase
			return d;
		end
	endfunction

endpackage

FILE: rtl/occupancy_dimmer_lamp_controller_unit.sv
// ----------------------------------------------------------------------------
// occupancy_dimmer_lamp_controller_unit
// Manual/auto lamp dimmer with vacancy timer and 100-step PWM.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item. One item is taken per
// cycle while req_stall is low; a result is offered after its item has
// passed the input register and the state update into the result register,
// where rsp_stall can hold it.
// Throughput is one item per cycle, set by the state_q update loop, and holds
// while the result side takes results as fast as they come.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while no item is in flight (not enforced).
module occupancy_dimmer_lamp_controller_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  odlc_pkg::req_item_t req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output odlc_pkg::rsp_item_t rsp_item,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import odlc_pkg::*;

	logic        valid_s1;
	req_item_t   item_s1;
	logic        advance;
	cfg_t        cfg_q;
	lamp_state_t state_q;
	lamp_state_t state_nxt;
	rsp_item_t   rsp_q;
	logic        rsp_valid_q;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	odlc_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_darkest     <= 12'd500;
			cfg_q.band_dim         <= 12'd1000;
			cfg_q.band_middle      <= 12'd2000;
			cfg_q.band_bright      <= 12'd3000;
			cfg_q.band_top         <= 12'd4095;
			cfg_q.vacancy_seconds  <= 16'd10;
			cfg_q.ticks_per_second <= 14'd10000;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BAND_DARKEST: cfg_q.band_darkest     <= cfg_data[11:0];
				REG_BAND_DIM:     cfg_q.band_dim         <= cfg_data[11:0];
				REG_BAND_MIDDLE:  cfg_q.band_middle      <= cfg_data[11:0];
				REG_BAND_BRIGHT:  cfg_q.band_bright      <= cfg_data[11:0];
				REG_BAND_TOP:     cfg_q.band_top         <= cfg_data[11:0];
				REG_VACANCY:      cfg_q.vacancy_seconds  <= cfg_data;
				REG_TICKS:        cfg_q.ticks_per_second <= cfg_data[13:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			state_q     <= '{mode_is_auto: 1'b0, level: LEVEL_MEDIUM, present: 1'b1,
			                 timing_active: 1'b0, tick_prescale: '0,
			                 elapsed_seconds: '0, pwm_phase: '0, drive_out: 1'b0};
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req_item;
		end
		if (advance) begin
			rsp_q.lamp_on   <= state_nxt.drive_out;
			rsp_q.level     <= state_nxt.level;
			rsp_q.auto_mode <= state_nxt.mode_is_auto;
			rsp_q.occupied  <= state_nxt.present;
		end
	end

`ifndef SYNTH
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.level <= LEVEL_MAX)
		else $error("brightness level out of range");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pwm_phase < PWM_STEPS)
		else $error("pwm phase out of range");

	a_lit_needs_presence: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!rsp_q.lamp_on || rsp_q.occupied))
		else $error("lamp lit while vacant");

	a_prescale_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.timing_active |=> $stable(state_q.tick_prescale))
		else $error("prescaler moved while timing stopped");
`endif

endmodule

FILE: rtl/odlc_step.sv
// ----------------------------------------------------------------------------
// odlc_step
// Next-state logic: applies one item to the controller state.
// ----------------------------------------------------------------------------
module odlc_step (
	input  odlc_pkg::req_item_t   item,
	input  odlc_pkg::cfg_t        cfg,
	input  odlc_pkg::lamp_state_t cur,
	output odlc_pkg::lamp_state_t nxt
);
	import odlc_pkg::*;

	logic [13:0] prescale_inc;
	logic [15:0] seconds_inc;
	logic [6:0]  phase_inc;
	logic [11:0] l;

	assign prescale_inc = cur.tick_prescale + 14'd1;
	assign seconds_inc  = cur.elapsed_seconds + 16'd1;
	assign phase_inc    = cur.pwm_phase + 7'd1;
	assign l            = item.light_level;

	always_comb begin
		nxt = cur;
		unique case (item.action)
			ACT_TICK: begin
				if (cur.timing_active) begin
					if (prescale_inc >= cfg.ticks_per_second) begin
						nxt.tick_prescale   = '0;
						nxt.elapsed_seconds = seconds_inc;
						if (seconds_inc >= cfg.vacancy_seconds) begin
							nxt.timing_active = 1'b0;
							nxt.present       = 1'b0;
						end
					end else begin
						nxt.tick_prescale = prescale_inc;
					end
				end
				nxt.pwm_phase = (phase_inc >= PWM_STEPS) ? 7'd0 : phase_inc;
				nxt.drive_out = nxt.present && (nxt.pwm_phase < duty_of_level(cur.level));
			end
			ACT_MODE: begin
				nxt.mode_is_auto = !cur.mode_is_auto;
				if (cur.mode_is_auto) begin
					nxt.present = 1'b1;
				end else begin
					nxt.level           = LEVEL_MEDIUM;
					nxt.elapsed_seconds = '0;
					nxt.timing_active   = 1'b1;
				end
			end
			ACT_UP: begin
				if (!cur.mode_is_auto) begin
					nxt.level = (cur.level >= LEVEL_MAX) ? 3'd0 : cur.level + 3'd1;
				end
			end
			ACT_DOWN: begin
				if (!cur.mode_is_auto) begin
					nxt.level = (cur.level == 3'd0) ? LEVEL_MAX : cur.level - 3'd1;
				end
			end
			ACT_PRESENCE: begin
				if (cur.mode_is_auto) begin
					nxt.present         = 1'b1;
					nxt.elapsed_seconds = '0;
					nxt.timing_active   = 1'b1;
				end
			end
			ACT_SAMPLE: begin
				if (cur.mode_is_auto && cur.present) begin
					priority if (l > 12'd0 && l < cfg.band_darkest) begin
						nxt.level = 3'd4;
					end else if (l > cfg.band_darkest && l < cfg.band_dim) begin
						nxt.level = 3'd3;
					end else if (l > cfg.band_dim && l < cfg.band_middle) begin
						nxt.level = 3'd2;
					end else if (l > cfg.band_middle && l < cfg.band_bright) begin
						nxt.level = 3'd1;
					end else if (l > cfg.band_bright && l < cfg.band_top) begin
						nxt.level = 3'd0;
					end else begin
						nxt.level = cur.level;
					end
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the occupancy dimmer lamp controller. A clocked
// driver feeds a queue of events (ticks, keys, presence, light samples) with
// random gaps. A clocked monitor stalls the result side at random and checks
// each result against a predictor of mode, level, presence, vacancy timer and
// PWM drive. The band and timer registers are reloaded between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import odlc_pkg::*;

	localparam logic [2:0] ACT_SPARE6  = 3'd6;
	localparam logic [2:0] ACT_SPARE7  = 3'd7;
	localparam int         QUIET_LIMIT = 2000;
	localparam int         PHASE_ITEMS = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_item_t   req_item = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_item_t   rsp_item;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	req_item_t lamp_events_q[$];
	rsp_item_t lamp_results_q[$];

	cfg_t        lamp_cfg;
	logic        auto_on;
	logic [2:0]  lamp_level;
	logic        someone_in;
	logic        timing_on;
	logic [13:0] prescale;
	logic [15:0] elapsed;
	logic [6:0]  pwm_phase;
	logic        lamp_drive;

	int        gap_left = 0;
	int        hold_left = 0;
	bit        calm_req = 1'b0;
	bit        calm_rsp = 1'b0;
	int        quiet = 0;
	int        faults = 0;
	rsp_item_t want;

	occupancy_dimmer_lamp_controller_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_item_t step_lamp(input req_item_t it);
		rsp_item_t   r;
		logic [13:0] nxt;
		logic [11:0] l;
		l = it.light_level;
		case (it.action)
			ACT_TICK: begin
				if (timing_on) begin
					nxt = prescale + 14'd1;
					if (nxt >= lamp_cfg.ticks_per_second) begin
						prescale = '0;
						elapsed = elapsed + 16'd1;
						if (elapsed >= lamp_cfg.vacancy_seconds) begin
							timing_on = 1'b0;
							someone_in = 1'b0;
						end
					end else begin
						prescale = nxt;
					end
				end
				pwm_phase = pwm_phase + 7'd1;
				if (pwm_phase >= PWM_STEPS)
					pwm_phase = '0;
				// duty is 25 percent per level step
				lamp_drive = someone_in && (pwm_phase < ({4'd0, lamp_level} * 7'd25));
			end
			ACT_MODE: begin
				auto_on = !auto_on;
				if (!auto_on) begin
					someone_in = 1'b1;
				end else begin
					lamp_level = LEVEL_MEDIUM;
					elapsed = '0;
					timing_on = 1'b1;
				end
			end
			ACT_UP: begin
				if (!auto_on)
					lamp_level = (lamp_level == LEVEL_MAX) ? 3'd0 : lamp_level + 3'd1;
			end
			ACT_DOWN: begin
				if (!auto_on)
					lamp_level = (lamp_level == 3'd0) ? LEVEL_MAX : lamp_level - 3'd1;
			end
			ACT_PRESENCE: begin
				if (auto_on) begin
					someone_in = 1'b1;
					elapsed = '0;
					timing_on = 1'b1;
				end
			end
			ACT_SAMPLE: begin
				if (auto_on && someone_in) begin
					if (l > 0 && l < lamp_cfg.band_darkest)
						lamp_level = 3'd4;
					else if (l > lamp_cfg.band_darkest && l < lamp_cfg.band_dim)
						lamp_level = 3'd3;
					else if (l > lamp_cfg.band_dim && l < lamp_cfg.band_middle)
						lamp_level = 3'd2;
					else if (l > lamp_cfg.band_middle && l < lamp_cfg.band_bright)
						lamp_level = 3'd1;
					else if (l > lamp_cfg.band_bright && l < lamp_cfg.band_top)
						lamp_level = 3'd0;
				end
			end
			default: ;
		endcase
		r.lamp_on   = lamp_drive;
		r.level     = lamp_level;
		r.auto_mode = auto_on;
		r.occupied  = someone_in;
		return r;
	endfunction

	function automatic int pick_pause(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [11:0] pick_light();
		int          r;
		logic [11:0] t;
		r = $urandom_range(0, 9);
		case ($urandom_range(0, 4))
			0: t = lamp_cfg.band_darkest;
			1: t = lamp_cfg.band_dim;
			2: t = lamp_cfg.band_middle;
			3: t = lamp_cfg.band_bright;
			default: t = lamp_cfg.band_top;
		endcase
		if (r == 0)
			return 12'd0;
		if (r == 1)
			return 12'hFFF;
		if (r < 6)
			return t + 12'($urandom_range(0, 2)) - 12'd1;
		return 12'($urandom_range(0, 4095));
	endfunction

	task automatic push_item(input logic [2:0] act, input logic [11:0] light);
		req_item_t it;
		it.action      = act;
		it.light_level = light;
		lamp_events_q.push_back(it);
	endtask

	// mostly ticks and well-formed key traffic, with runs of ticks so the
	// vacancy timer gets to expire
	task automatic queue_random(input int n);
		int k;
		int r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(5, 25)) begin
					push_item(ACT_TICK, 12'($urandom_range(0, 4095)));
					k++;
				end
			end else begin
				if (r < 45)
					push_item(ACT_TICK, 12'($urandom_range(0, 4095)));
				else if (r < 52)
					push_item(ACT_MODE, 12'($urandom_range(0, 4095)));
				else if (r < 62)
					push_item(ACT_UP, 12'($urandom_range(0, 4095)));
				else if (r < 70)
					push_item(ACT_DOWN, 12'($urandom_range(0, 4095)));
				else if (r < 80)
					push_item(ACT_PRESENCE, 12'($urandom_range(0, 4095)));
				else if (r < 97)
					push_item(ACT_SAMPLE, pick_light());
				else if (r < 99)
					push_item(ACT_SPARE6, 12'($urandom_range(0, 4095)));
				else
					push_item(ACT_SPARE7, 12'($urandom_range(0, 4095)));
				k++;
			end
		end
	endtask

	task automatic wait_idle();
		while (lamp_events_q.size() != 0 || req_valid || lamp_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_BAND_DARKEST: lamp_cfg.band_darkest = val[11:0];
			REG_BAND_DIM:     lamp_cfg.band_dim = val[11:0];
			REG_BAND_MIDDLE:  lamp_cfg.band_middle = val[11:0];
			REG_BAND_BRIGHT:  lamp_cfg.band_bright = val[11:0];
			REG_BAND_TOP:     lamp_cfg.band_top = val[11:0];
			REG_VACANCY:      lamp_cfg.vacancy_seconds = val;
			REG_TICKS:        lamp_cfg.ticks_per_second = val[13:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_cfg(input int darkest, input int dim, input int middle,
			input int bright, input int top, input int vac, input int tps);
		write_reg(REG_BAND_DARKEST, 16'(darkest));
		write_reg(REG_BAND_DIM, 16'(dim));
		write_reg(REG_BAND_MIDDLE, 16'(middle));
		write_reg(REG_BAND_BRIGHT, 16'(bright));
		write_reg(REG_BAND_TOP, 16'(top));
		write_reg(REG_VACANCY, 16'(vac));
		write_reg(REG_TICKS, 16'(tps));
	endtask

	task automatic load_rising(input int vac, input int tps);
		int b0;
		int b1;
		int b2;
		int b3;
		b0 = $urandom_range(1, 700);
		b1 = b0 + $urandom_range(1, 700);
		b2 = b1 + $urandom_range(1, 700);
		b3 = b2 + $urandom_range(1, 700);
		load_cfg(b0, b1, b2, b3, $urandom_range(b3 + 1, 4095), vac, tps);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				lamp_results_q.push_back(step_lamp(req_item));
				if ($urandom_range(0, 49) == 0)
					calm_req = !calm_req;
				gap_left = pick_pause(calm_req);
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (lamp_events_q.size() != 0) begin
					req_item  <= lamp_events_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (lamp_results_q.size() == 0) begin
					$error("result item with nothing expected");
					faults++;
				end else begin
					want = lamp_results_q.pop_front();
					if (rsp_item.lamp_on !== want.lamp_on) begin
						$error("lamp_on: expected %0d, got %0d", want.lamp_on, rsp_item.lamp_on);
						faults++;
					end
					if (rsp_item.level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, rsp_item.level);
						faults++;
					end
					if (rsp_item.auto_mode !== want.auto_mode) begin
						$error("auto_mode: expected %0d, got %0d", want.auto_mode,
							rsp_item.auto_mode);
						faults++;
					end
					if (rsp_item.occupied !== want.occupied) begin
						$error("occupied: expected %0d, got %0d", want.occupied,
							rsp_item.occupied);
						faults++;
					end
				end
				if ($urandom_range(0, 49) == 0)
					calm_rsp = !calm_rsp;
				hold_left = pick_pause(calm_rsp);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		lamp_cfg.band_darkest     = 12'd500;
		lamp_cfg.band_dim         = 12'd1000;
		lamp_cfg.band_middle      = 12'd2000;
		lamp_cfg.band_bright      = 12'd3000;
		lamp_cfg.band_top         = 12'd4095;
		lamp_cfg.vacancy_seconds  = 16'd10;
		lamp_cfg.ticks_per_second = 14'd10000;
		auto_on    = 1'b0;
		lamp_level = LEVEL_MEDIUM;
		someone_in = 1'b1;
		timing_on  = 1'b0;
		prescale   = '0;
		elapsed    = '0;
		pwm_phase  = '0;
		lamp_drive = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// manual keys, wrap both ways, keys in the wrong mode, spare actions
		push_item(ACT_SAMPLE, 12'hFFF);
		push_item(ACT_UP, 12'd0);
		push_item(ACT_UP, 12'd0);
		push_item(ACT_UP, 12'd0);
		push_item(ACT_DOWN, 12'd0);
		push_item(ACT_PRESENCE, 12'd0);
		push_item(ACT_SPARE6, 12'd0);
		push_item(ACT_SPARE7, 12'hFFF);
		push_item(ACT_TICK, 12'hFFF);
		push_item(ACT_TICK, 12'd0);
		push_item(ACT_TICK, 12'd0);
		// auto mode: zero, around band_darkest, on band_dim, mid-band, at band_top
		push_item(ACT_MODE, 12'd0);
		push_item(ACT_SAMPLE, 12'd0);
		push_item(ACT_SAMPLE, 12'd499);
		push_item(ACT_SAMPLE, 12'd500);
		push_item(ACT_SAMPLE, 12'd501);
		push_item(ACT_SAMPLE, 12'd1000);
		push_item(ACT_SAMPLE, 12'd1500);
		push_item(ACT_SAMPLE, 12'd2500);
		push_item(ACT_SAMPLE, 12'd3500);
		push_item(ACT_SAMPLE, 12'd4094);
		push_item(ACT_SAMPLE, 12'hFFF);
		push_item(ACT_UP, 12'd0);
		push_item(ACT_DOWN, 12'd0);
		push_item(ACT_PRESENCE, 12'd0);
		push_item(ACT_TICK, 12'd0);
		push_item(ACT_MODE, 12'd0);
		queue_random(PHASE_ITEMS);
		wait_idle();

		load_rising(1, 1);
		queue_random(PHASE_ITEMS);
		wait_idle();

		// overlapping bands
		load_cfg(4095, 0, 4095, 0, 4095, 3, 2);
		queue_random(PHASE_ITEMS);
		wait_idle();

		load_cfg($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), 65535, 16383);
		queue_random(PHASE_ITEMS);
		wait_idle();

		// seconds build up here, then both periods drop below the counts
		load_rising(65535, 1);
		queue_random(PHASE_ITEMS);
		wait_idle();

		load_cfg(0, 0, 0, 0, 0, 0, 0);
		queue_random(PHASE_ITEMS);
		wait_idle();

		load_rising($urandom_range(1, 4), $urandom_range(1, 5));
		queue_random(PHASE_ITEMS);
		wait_idle();

		repeat (6) @(posedge clk);
		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
